// ===== src/ptn_pkg.sv =====
// Shared constants and types for the plain text normaliser.
package ptn_pkg;

    localparam int MAX_WS     = 32;
    localparam int WS_CNT_W   = $clog2(MAX_WS + 1);
    localparam int WS_IDX_W   = (MAX_WS > 1) ? $clog2(MAX_WS) : 1;
    localparam int FIFO_DEPTH = 2;

    localparam logic [7:0] BYTE_MARK0 = 8'hEF;
    localparam logic [7:0] BYTE_MARK1 = 8'hBB;
    localparam logic [7:0] BYTE_MARK2 = 8'hBF;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_TAB   = 8'h09;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;

    localparam logic [1:0] MAX_BLANK_RESET = 2'd2;
    localparam logic [1:0] BLANK_SAT       = 2'd3;

    // Work for the back end: marks, then held LFs, then held whitespace, then the text byte.
    typedef struct packed {
        logic [1:0]          marks;
        logic [2:0]          nl;
        logic [WS_CNT_W-1:0] ws_cnt;
        logic [MAX_WS-1:0]   ws_kinds;
        logic                txt;
        logic [7:0]          txt_byte;
        logic                last;
        logic                ovf;
    } t_cmd;

endpackage

// ===== src/ptn_cmd_fifo.sv =====
// Short command queue between the classifier and the output sequencer.
module ptn_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ptn_pkg::t_cmd i_data,
    input  logic          i_pop,
    output ptn_pkg::t_cmd o_data,
    output logic          o_full,
    output logic          o_empty
);

    localparam int PTR_W = (ptn_pkg::FIFO_DEPTH > 1) ? $clog2(ptn_pkg::FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(ptn_pkg::FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(ptn_pkg::FIFO_DEPTH - 1);

    ptn_pkg::t_cmd    r_mem [ptn_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CNT_W'(ptn_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CNT_W'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== src/ptn_front.sv =====
// Classifier: tracks line, mark and whitespace state and queues output work.
module ptn_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [7:0]    i_in_byte,
    input  logic          i_last,
    input  logic          i_cfg_wr_en,
    input  logic [1:0]    i_cfg_wr_data,
    input  logic          i_cmd_full,
    output logic          o_cmd_push,
    output ptn_pkg::t_cmd o_cmd
);

    logic                         r_at_start,   n_at_start;
    logic [1:0]                   r_bom_cnt,    n_bom_cnt;
    logic                         r_cr_seen,    n_cr_seen;
    logic                         r_line_text,  n_line_text;
    logic [1:0]                   r_blank_run,  n_blank_run;
    logic [2:0]                   r_pend_nl,    n_pend_nl;
    logic [ptn_pkg::WS_CNT_W-1:0] r_ws_cnt,     n_ws_cnt;
    logic [ptn_pkg::MAX_WS-1:0]   r_ws_kinds,   n_ws_kinds;
    logic                         r_ovf,        n_ovf;
    logic [1:0]                   r_max_blank;

    logic       accept;
    logic       do_plain;
    logic       nl_ev;
    logic [7:0] exp_byte;
    logic [1:0] marks;

    assign accept = i_push && !i_cmd_full;

    always_comb begin
        n_at_start  = r_at_start;
        n_bom_cnt   = r_bom_cnt;
        n_cr_seen   = r_cr_seen;
        n_line_text = r_line_text;
        n_blank_run = r_blank_run;
        n_pend_nl   = r_pend_nl;
        n_ws_cnt    = r_ws_cnt;
        n_ws_kinds  = r_ws_kinds;
        n_ovf       = r_ovf;
        do_plain    = 1'b0;
        nl_ev       = 1'b0;
        marks       = 2'b00;
        o_cmd       = '0;
        o_cmd_push  = 1'b0;

        case (r_bom_cnt)
            2'd0:    exp_byte = ptn_pkg::BYTE_MARK0;
            2'd1:    exp_byte = ptn_pkg::BYTE_MARK1;
            default: exp_byte = ptn_pkg::BYTE_MARK2;
        endcase

        if (accept) begin
            if (r_at_start) begin
                if (i_in_byte == exp_byte) begin
                    if (r_bom_cnt >= 2'd2) begin
                        n_bom_cnt  = 2'd0;
                        n_at_start = 1'b0;
                    end else begin
                        n_bom_cnt = r_bom_cnt + 2'd1;
                        if (i_last) begin
                            marks = (r_bom_cnt == 2'd0) ? 2'b01 : 2'b11;
                        end
                    end
                end else begin
                    case (r_bom_cnt)
                        2'd0:    marks = 2'b00;
                        2'd1:    marks = 2'b01;
                        default: marks = 2'b11;
                    endcase
                    n_bom_cnt  = 2'd0;
                    n_at_start = 1'b0;
                    do_plain   = 1'b1;
                end
            end else begin
                do_plain = 1'b1;
            end

            // released mark bytes count as text on the line
            if (marks != 2'b00) begin
                n_line_text = 1'b1;
            end

            if (do_plain) begin
                if (i_in_byte == ptn_pkg::BYTE_CR) begin
                    n_cr_seen = 1'b1;
                    nl_ev     = 1'b1;
                end else if (i_in_byte == ptn_pkg::BYTE_LF) begin
                    if (n_cr_seen) begin
                        n_cr_seen = 1'b0;
                    end else begin
                        nl_ev = 1'b1;
                    end
                end else begin
                    n_cr_seen = 1'b0;
                    if (i_in_byte == ptn_pkg::BYTE_SPACE || i_in_byte == ptn_pkg::BYTE_TAB) begin
                        if (n_ws_cnt < ptn_pkg::WS_CNT_W'(ptn_pkg::MAX_WS)) begin
                            n_ws_kinds[n_ws_cnt[ptn_pkg::WS_IDX_W-1:0]] =
                                (i_in_byte == ptn_pkg::BYTE_TAB);
                            n_ws_cnt = n_ws_cnt + ptn_pkg::WS_CNT_W'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else if (i_in_byte >= ptn_pkg::CTRL_LIMIT) begin
                        o_cmd.nl       = n_pend_nl;
                        o_cmd.ws_cnt   = n_ws_cnt;
                        o_cmd.ws_kinds = n_ws_kinds;
                        o_cmd.txt      = 1'b1;
                        o_cmd.txt_byte = i_in_byte;
                        n_pend_nl      = 3'd0;
                        n_ws_cnt       = '0;
                        n_ws_kinds     = '0;
                        n_line_text    = 1'b1;
                    end
                end

                if (nl_ev) begin
                    if (n_line_text) begin
                        n_pend_nl   = 3'd1;
                        n_blank_run = 2'd0;
                    end else begin
                        if (n_blank_run < r_max_blank) begin
                            n_pend_nl = n_pend_nl + 3'd1;
                        end
                        if (n_blank_run < ptn_pkg::BLANK_SAT) begin
                            n_blank_run = n_blank_run + 2'd1;
                        end
                    end
                    n_line_text = 1'b0;
                    n_ws_cnt    = '0;
                    n_ws_kinds  = '0;
                end
            end

            o_cmd.marks = marks;
            o_cmd.last  = i_last;
            o_cmd.ovf   = n_ovf;
            o_cmd_push  = (marks != 2'b00) || o_cmd.txt || i_last;

            if (i_last) begin
                n_at_start  = 1'b1;
                n_bom_cnt   = 2'd0;
                n_cr_seen   = 1'b0;
                n_line_text = 1'b0;
                n_blank_run = 2'd0;
                n_pend_nl   = 3'd0;
                n_ws_cnt    = '0;
                n_ws_kinds  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start  <= 1'b1;
            r_bom_cnt   <= 2'd0;
            r_cr_seen   <= 1'b0;
            r_line_text <= 1'b0;
            r_blank_run <= 2'd0;
            r_pend_nl   <= 3'd0;
            r_ws_cnt    <= '0;
            r_ws_kinds  <= '0;
            r_ovf       <= 1'b0;
            r_max_blank <= ptn_pkg::MAX_BLANK_RESET;
        end else begin
            r_at_start  <= n_at_start;
            r_bom_cnt   <= n_bom_cnt;
            r_cr_seen   <= n_cr_seen;
            r_line_text <= n_line_text;
            r_blank_run <= n_blank_run;
            r_pend_nl   <= n_pend_nl;
            r_ws_cnt    <= n_ws_cnt;
            r_ws_kinds  <= n_ws_kinds;
            r_ovf       <= n_ovf;
            if (i_cfg_wr_en) begin
                r_max_blank <= i_cfg_wr_data;
            end
        end
    end

endmodule

// ===== src/ptn_back.sv =====
// Output sequencer: expands a queued command, one result per cycle unless held.
module ptn_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ptn_pkg::t_cmd i_cmd,
    input  logic          i_cmd_empty,
    output logic          o_cmd_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [7:0]    o_out_byte,
    output logic          o_has_byte,
    output logic          o_end_of_stream,
    output logic          o_ws_overflow
);

    logic                         r_busy;
    logic [1:0]                   r_marks,  n_marks;
    logic [2:0]                   r_nl,     n_nl;
    logic [ptn_pkg::WS_CNT_W-1:0] r_ws,     n_ws;
    logic [ptn_pkg::MAX_WS-1:0]   r_kinds,  n_kinds;
    logic                         r_txt,    n_txt;
    logic [7:0]                   r_byte;
    logic                         r_last;
    logic                         r_ovf;

    logic                         r_out_valid;
    logic [7:0]                   r_out_byte;
    logic                         r_out_has;
    logic                         r_out_eos;
    logic                         r_out_ovf;

    logic       load;
    logic       emit;
    logic       e_final;
    logic       e_has;
    logic [7:0] e_byte;

    assign load      = !r_busy && !i_cmd_empty;
    assign emit      = r_busy && (!r_out_valid || i_pop);
    assign o_cmd_pop = load;

    always_comb begin
        n_marks = r_marks;
        n_nl    = r_nl;
        n_ws    = r_ws;
        n_kinds = r_kinds;
        n_txt   = r_txt;
        e_has   = 1'b1;
        e_byte  = 8'h00;
        if (r_marks != 2'b00) begin
            e_byte  = r_marks[0] ? ptn_pkg::BYTE_MARK0 : ptn_pkg::BYTE_MARK1;
            n_marks = r_marks[0] ? (r_marks & 2'b10) : 2'b00;
        end else if (r_nl != 3'd0) begin
            e_byte = ptn_pkg::BYTE_LF;
            n_nl   = r_nl - 3'd1;
        end else if (r_ws != '0) begin
            e_byte  = r_kinds[0] ? ptn_pkg::BYTE_TAB : ptn_pkg::BYTE_SPACE;
            n_ws    = r_ws - ptn_pkg::WS_CNT_W'(1);
            n_kinds = r_kinds >> 1;
        end else if (r_txt) begin
            e_byte = r_byte;
            n_txt  = 1'b0;
        end else begin
            // bare end-of-stream marker
            e_has = 1'b0;
        end
        e_final = (n_marks == 2'b00) && (n_nl == 3'd0) && (n_ws == '0) && !n_txt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (emit && e_final) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_marks <= i_cmd.marks;
            r_nl    <= i_cmd.nl;
            r_ws    <= i_cmd.ws_cnt;
            r_kinds <= i_cmd.ws_kinds;
            r_txt   <= i_cmd.txt;
            r_byte  <= i_cmd.txt_byte;
            r_last  <= i_cmd.last;
            r_ovf   <= i_cmd.ovf;
        end else if (emit) begin
            r_marks <= n_marks;
            r_nl    <= n_nl;
            r_ws    <= n_ws;
            r_kinds <= n_kinds;
            r_txt   <= n_txt;
        end
        if (emit) begin
            r_out_byte <= e_byte;
            r_out_has  <= e_has;
            r_out_eos  <= e_final && r_last;
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_empty         = !r_out_valid;
    assign o_out_byte      = r_out_byte;
    assign o_has_byte      = r_out_has;
    assign o_end_of_stream = r_out_eos;
    assign o_ws_overflow   = r_out_ovf;

endmodule

// ===== src/plain_text_normalizer.sv =====
// Top level of the plain text normaliser.
// Input side is a queue write port: a byte transaction (i_in_byte, i_last)
// is taken on a clock edge with push high and full low; i_last marks the
// final byte of a file. Results come out of a queue read port: while empty
// is low the oldest result sits on o_out_byte, o_has_byte, o_end_of_stream
// and o_ws_overflow, and pop takes it. o_has_byte low is a bare end marker.
// max_blank_lines is written through i_cfg_wr_en / i_cfg_wr_data; the user
// must write it only while idle: the block does not enforce this. A byte
// that yields output passes the command queue and the sequencer's registers
// to reach the result ports. The classifier takes one byte per cycle while
// full is low; held newlines and whitespace come out one per cycle while
// pop keeps up, and full rises once the 2-entry command queue fills.
// Reset empties the queue and output register, clears all stream state and
// the overflow flag, and sets max_blank_lines to 2. When pop stays low the
// output register holds its result, the sequencer and queue fill, and full
// then stalls the input.
module plain_text_normalizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_last,
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_wr_data,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_has_byte,
    output logic       o_end_of_stream,
    output logic       o_ws_overflow
);

    ptn_pkg::t_cmd front_cmd;
    ptn_pkg::t_cmd head_cmd;
    logic          cmd_push;
    logic          cmd_pop;
    logic          cmd_full;
    logic          cmd_empty;

    assign full = cmd_full;

    ptn_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_in_byte     (i_in_byte),
        .i_last        (i_last),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd_full    (cmd_full),
        .o_cmd_push    (cmd_push),
        .o_cmd         (front_cmd)
    );

    ptn_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (front_cmd),
        .i_pop   (cmd_pop),
        .o_data  (head_cmd),
        .o_full  (cmd_full),
        .o_empty (cmd_empty)
    );

    ptn_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (head_cmd),
        .i_cmd_empty     (cmd_empty),
        .o_cmd_pop       (cmd_pop),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_out_byte      (o_out_byte),
        .o_has_byte      (o_has_byte),
        .o_end_of_stream (o_end_of_stream),
        .o_ws_overflow   (o_ws_overflow)
    );

endmodule

// ===== src/ptn_checker.sv =====
// Port-level checks for the plain text normaliser, bound to the top level.
module ptn_port_checks (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_out_byte,
    input logic       o_has_byte,
    input logic       o_end_of_stream,
    input logic       o_ws_overflow
);

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_bare_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_has_byte) |-> o_end_of_stream)
        else $error("bare marker without end of stream");

    a_bare_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_has_byte) |-> (o_out_byte == 8'h00))
        else $error("bare marker carries a byte");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && $past(!empty && pop && o_ws_overflow)) |-> o_ws_overflow)
        else $error("overflow flag fell between transactions");

endmodule

bind plain_text_normalizer ptn_port_checks u_ptn_port_checks (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .empty           (empty),
    .pop             (pop),
    .o_out_byte      (o_out_byte),
    .o_has_byte      (o_has_byte),
    .o_end_of_stream (o_end_of_stream),
    .o_ws_overflow   (o_ws_overflow)
);

// ===== tb/ptn_checker.sv =====
// Checker for the plain text normaliser: predicts the cleaned stream and compares results.
module ptn_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_full,
    input  logic [7:0] i_in_byte,
    input  logic       i_last,
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_wr_data,
    input  logic       i_empty,
    input  logic       i_pop,
    input  logic [7:0] i_out_byte,
    input  logic       i_has_byte,
    input  logic       i_end_of_stream,
    input  logic       i_ws_overflow,
    output int         o_fail_count,
    output int         o_outstanding,
    output int         o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       eos;
        logic       ovf;
    } t_cleaned;

    t_cleaned cleaned_q[$];
    t_cleaned burst_q[$];

    logic [1:0]                 blank_cap;
    logic                       in_mark;
    logic [1:0]                 mark_cnt;
    logic                       after_cr;
    logic                       line_text;
    logic [1:0]                 blanks;
    logic [2:0]                 held_nl;
    int                         held_ws;
    logic [ptn_pkg::MAX_WS-1:0] held_tabs;
    logic                       ws_ovf;
    int                         fails = 0;
    int                         checked = 0;

    task automatic clear_stream();
        in_mark   = 1'b1;
        mark_cnt  = 2'd0;
        after_cr  = 1'b0;
        line_text = 1'b0;
        blanks    = 2'd0;
        held_nl   = 3'd0;
        held_ws   = 0;
        held_tabs = '0;
    endtask

    task automatic add_result(input logic [7:0] b, input logic has);
        t_cleaned item;
        item.data = b;
        item.has  = has;
        item.eos  = 1'b0;
        item.ovf  = 1'b0;
        burst_q.insert(burst_q.size(), item);
    endtask

    task automatic emit_text(input logic [7:0] b);
        int i;
        for (i = 0; i < held_nl; i++) add_result(ptn_pkg::BYTE_LF, 1'b1);
        for (i = 0; i < held_ws; i++) begin
            add_result(held_tabs[i] ? ptn_pkg::BYTE_TAB : ptn_pkg::BYTE_SPACE, 1'b1);
        end
        add_result(b, 1'b1);
        held_nl   = 3'd0;
        held_ws   = 0;
        held_tabs = '0;
        line_text = 1'b1;
    endtask

    task automatic take_newline();
        if (line_text) begin
            held_nl = 3'd1;
            blanks  = 2'd0;
        end else begin
            if (blanks < blank_cap) held_nl = held_nl + 3'd1;
            if (blanks < ptn_pkg::BLANK_SAT) blanks = blanks + 2'd1;
        end
        line_text = 1'b0;
        held_ws   = 0;
        held_tabs = '0;
    endtask

    task automatic classify(input logic [7:0] b);
        if (b == ptn_pkg::BYTE_CR) begin
            after_cr = 1'b1;
            take_newline();
        end else if (b == ptn_pkg::BYTE_LF) begin
            if (after_cr) after_cr = 1'b0;
            else take_newline();
        end else begin
            after_cr = 1'b0;
            if (b == ptn_pkg::BYTE_SPACE || b == ptn_pkg::BYTE_TAB) begin
                if (held_ws < ptn_pkg::MAX_WS) begin
                    held_tabs[held_ws] = (b == ptn_pkg::BYTE_TAB);
                    held_ws++;
                end else begin
                    ws_ovf = 1'b1;
                end
            end else if (b >= ptn_pkg::CTRL_LIMIT) begin
                emit_text(b);
            end
        end
    endtask

    task automatic release_marks();
        int i;
        for (i = 0; i < mark_cnt; i++) begin
            emit_text(i == 0 ? ptn_pkg::BYTE_MARK0 : ptn_pkg::BYTE_MARK1);
        end
        mark_cnt = 2'd0;
        in_mark  = 1'b0;
    endtask

    task automatic normalise_byte(input logic [7:0] b, input logic l);
        logic [7:0] want_mark;
        int i;
        burst_q.delete();
        if (in_mark) begin
            want_mark = (mark_cnt == 2'd0) ? ptn_pkg::BYTE_MARK0 :
                        (mark_cnt == 2'd1) ? ptn_pkg::BYTE_MARK1 : ptn_pkg::BYTE_MARK2;
            if (b == want_mark) begin
                if (mark_cnt >= 2'd2) begin
                    mark_cnt = 2'd0;
                    in_mark  = 1'b0;
                end else begin
                    mark_cnt = mark_cnt + 2'd1;
                    if (l) release_marks();
                end
            end else begin
                release_marks();
                classify(b);
            end
        end else begin
            classify(b);
        end
        if (l) begin
            if (burst_q.size() == 0) add_result(8'h00, 1'b0);
            burst_q[burst_q.size() - 1].eos = 1'b1;
            clear_stream();
        end
        for (i = 0; i < burst_q.size(); i++) begin
            burst_q[i].ovf = ws_ovf;
            cleaned_q.insert(cleaned_q.size(), burst_q[i]);
        end
    endtask

    always @(posedge i_clk) begin
        t_cleaned got;
        t_cleaned want;
        if (!i_rst_n) begin
            clear_stream();
            blank_cap = ptn_pkg::MAX_BLANK_RESET;
            ws_ovf    = 1'b0;
            cleaned_q.delete();
        end else begin
            if (i_cfg_wr_en) blank_cap = i_cfg_wr_data;
            if (i_push && !i_full) normalise_byte(i_in_byte, i_last);
            if (i_pop && !i_empty) begin
                got = '{i_out_byte, i_has_byte, i_end_of_stream, i_ws_overflow};
                if (cleaned_q.size() == 0) begin
                    $error("unexpected result transaction: out_byte %02h has_byte %0b",
                           got.data, got.has);
                    fails++;
                end else begin
                    want = cleaned_q.pop_front();
                    checked++;
                    if (got.data !== want.data) begin
                        $error("out_byte: expected %02h, got %02h", want.data, got.data);
                        fails++;
                    end
                    if (got.has !== want.has) begin
                        $error("has_byte: expected %0b, got %0b", want.has, got.has);
                        fails++;
                    end
                    if (got.eos !== want.eos) begin
                        $error("end_of_stream: expected %0b, got %0b", want.eos, got.eos);
                        fails++;
                    end
                    if (got.ovf !== want.ovf) begin
                        $error("ws_overflow: expected %0b, got %0b", want.ovf, got.ovf);
                        fails++;
                    end
                end
            end
        end
        o_fail_count  <= fails;
        o_outstanding <= cleaned_q.size();
        o_checked     <= checked;
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the normaliser testbench: clock, reset, stimulus, stalls and the verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT     = 5_000_000;
    localparam int LONG_HOLD = 300;
    localparam int SETTLE    = 10;
    localparam int N_ITEMS   = 480;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [7:0] in_byte;
    logic       last_in;
    logic       cfg_en;
    logic [1:0] cfg_data;
    logic       empty;
    logic       pop;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       eos;
    logic       ws_ovf;

    int fail_count;
    int outstanding;
    int checked;

    int         cycles = 0;
    int         items = 0;
    int         streams = 0;
    int         hold_req = 0;
    logic       calm = 1'b0;
    logic       rx_calm = 1'b0;
    logic [7:0] stream_q[$];
    logic [8:0] directed_seq[$];
    logic [1:0] caps[4] = '{2'd0, 2'd3, 2'd1, 2'd2};

    plain_text_normalizer uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_in_byte      (in_byte),
        .i_last         (last_in),
        .i_cfg_wr_en    (cfg_en),
        .i_cfg_wr_data  (cfg_data),
        .empty          (empty),
        .pop            (pop),
        .o_out_byte     (out_byte),
        .o_has_byte     (has_byte),
        .o_end_of_stream(eos),
        .o_ws_overflow  (ws_ovf)
    );

    ptn_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_full         (full),
        .i_in_byte      (in_byte),
        .i_last         (last_in),
        .i_cfg_wr_en    (cfg_en),
        .i_cfg_wr_data  (cfg_data),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_out_byte     (out_byte),
        .i_has_byte     (has_byte),
        .i_end_of_stream(eos),
        .i_ws_overflow  (ws_ovf),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding),
        .o_checked      (checked)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // Result side: random pop gaps, plus a long hold on request.
    initial begin
        int gap_left;
        int hold_left;
        int holds_seen;
        pop        = 1'b0;
        gap_left   = 0;
        hold_left  = 0;
        holds_seen = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (holds_seen != hold_req) begin
                holds_seen = hold_req;
                hold_left  = LONG_HOLD - 1;
                pop <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                pop <= 1'b0;
            end else if (!rx_calm && $urandom_range(0, 99) < 30) begin
                gap_left = idle_len() - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic l);
        int gap;
        gap = (!calm && $urandom_range(0, 99) < 35) ? idle_len() : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push    <= 1'b1;
        in_byte <= b;
        last_in <= l;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
        items++;
    endtask

    task automatic send_stream();
        int i;
        for (i = 0; i < stream_q.size(); i++) send_byte(stream_q[i], i == stream_q.size() - 1);
        streams++;
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_cap(input logic [1:0] v);
        cfg_en   <= 1'b1;
        cfg_data <= v;
        @(negedge i_clk);
        cfg_en   <= 1'b0;
    endtask

    task automatic add_byte(input logic [7:0] b);
        stream_q.insert(stream_q.size(), b);
    endtask

    task automatic build_stream(input logic long_ws);
        int target;
        int r;
        int n;
        int k;
        stream_q.delete();
        target = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 20);
        r = $urandom_range(0, 99);
        if (r < 15) begin
            add_byte(ptn_pkg::BYTE_MARK0);
            add_byte(ptn_pkg::BYTE_MARK1);
            add_byte(ptn_pkg::BYTE_MARK2);
        end else if (r < 20) begin
            add_byte(ptn_pkg::BYTE_MARK0);
        end else if (r < 24) begin
            add_byte(ptn_pkg::BYTE_MARK0);
            add_byte(ptn_pkg::BYTE_MARK1);
        end
        while (stream_q.size() < target) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                n = $urandom_range(1, 6);
                repeat (n) begin
                    add_byte(($urandom_range(0, 19) == 0) ?
                             8'($urandom_range(128, 255)) :
                             8'($urandom_range(33, 126)));
                end
            end else if (r < 60) begin
                n = (long_ws && $urandom_range(0, 9) == 0) ?
                    $urandom_range(30, 40) : $urandom_range(1, 4);
                repeat (n) begin
                    add_byte($urandom_range(0, 1) ? ptn_pkg::BYTE_TAB : ptn_pkg::BYTE_SPACE);
                end
            end else if (r < 85) begin
                n = $urandom_range(1, 5);
                repeat (n) begin
                    k = $urandom_range(0, 2);
                    if (k != 0) add_byte(ptn_pkg::BYTE_CR);
                    if (k != 2) add_byte(ptn_pkg::BYTE_LF);
                end
            end else if (r < 92) begin
                add_byte(8'($urandom_range(0, 31)));
            end else if (r < 95) begin
                // CR, stray control byte, LF
                add_byte(ptn_pkg::BYTE_CR);
                add_byte(8'($urandom_range(0, 31)));
                add_byte(ptn_pkg::BYTE_LF);
            end else begin
                add_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        int s;
        int i;
        int n_cfg;
        i_rst_n  = 1'b0;
        push     = 1'b0;
        in_byte  = 8'h00;
        last_in  = 1'b0;
        cfg_en   = 1'b0;
        cfg_data = 2'd0;
        n_cfg    = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        directed_seq = '{
            {1'b0, ptn_pkg::BYTE_MARK0}, {1'b0, ptn_pkg::BYTE_MARK1},
            {1'b0, ptn_pkg::BYTE_MARK2}, {1'b0, 8'h41},
            {1'b0, ptn_pkg::BYTE_SPACE}, {1'b0, ptn_pkg::BYTE_TAB},
            {1'b0, ptn_pkg::BYTE_CR}, {1'b0, ptn_pkg::BYTE_LF},
            {1'b0, ptn_pkg::BYTE_LF}, {1'b0, ptn_pkg::BYTE_LF},
            {1'b0, ptn_pkg::BYTE_LF}, {1'b1, 8'h42},
            {1'b0, ptn_pkg::BYTE_MARK0}, {1'b1, 8'h78},
            {1'b0, ptn_pkg::BYTE_MARK0}, {1'b0, ptn_pkg::BYTE_MARK1},
            {1'b0, 8'h00}, {1'b0, ptn_pkg::BYTE_CR},
            {1'b0, 8'h1F}, {1'b0, ptn_pkg::BYTE_LF}, {1'b1, 8'hFF},
            {1'b1, ptn_pkg::BYTE_MARK0},
            {1'b0, ptn_pkg::BYTE_MARK0}, {1'b1, ptn_pkg::BYTE_MARK1},
            {1'b0, 8'h7A}, {1'b0, ptn_pkg::BYTE_LF}, {1'b1, ptn_pkg::BYTE_SPACE}
        };
        for (i = 0; i < directed_seq.size(); i++) begin
            send_byte(directed_seq[i][7:0], directed_seq[i][8]);
            if (directed_seq[i][8]) streams++;
        end

        s = 0;
        while (items < N_ITEMS + directed_seq.size()) begin
            if (s % 10 == 0) begin
                wait_drained();
                write_cap(caps[n_cfg % 4]);
                n_cfg++;
            end
            calm = (s % 7 == 3);
            rx_calm <= calm;
            if (s == 15) begin
                // long result stall while text keeps coming
                hold_req <= hold_req + 1;
                stream_q.delete();
                repeat (40) add_byte(8'($urandom_range(33, 126)));
                send_stream();
            end else begin
                build_stream(items > N_ITEMS / 2);
                send_stream();
            end
            s++;
        end

        push <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (20) @(posedge i_clk);

        $display("%0d streams, %0d bytes in, %0d results checked", streams, items, checked);
        $display("%0d blank line cap settings, one long output stall, overflow flag %0b",
                 n_cfg, ws_ovf);
        if (fail_count == 0 && outstanding == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
